>>> sv/alrq_pkg.sv
package alrq_pkg;

    localparam int SRC_W           = 3;
    localparam int SRC_COUNT       = 2 ** SRC_W;
    localparam int NUM_SOURCES_DEF = 8;
    localparam int OP_W            = 2;
    localparam int DATA_W          = 8;

    localparam logic [OP_W-1:0]   OP_ALERT      = 2'd0;
    localparam logic [OP_W-1:0]   OP_RECV       = 2'd1;
    localparam logic [OP_W-1:0]   OP_START_READ = 2'd2;
    localparam logic [DATA_W-1:0] EMPTY_BYTE    = 8'hFF;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [SRC_W-1:0]  source_id;
        logic [DATA_W-1:0] alert_value;
    } in_word_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              nack;
        logic              irq_level;
    } out_word_t;

endpackage

>>> sv/alrq_in_reg.sv
module alrq_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  alrq_pkg::in_word_t req,
    input  logic               step,
    output logic               held,
    output alrq_pkg::in_word_t item
);
    import alrq_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t item_reg;

    assign req_ready  = !valid_reg || step;
    assign valid_next = (req_valid && req_ready) || (valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
    end

    assign held = valid_reg;
    assign item = item_reg;

endmodule

>>> sv/alrq_core.sv
module alrq_core #(
    parameter int NUM_SOURCES = alrq_pkg::NUM_SOURCES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  alrq_pkg::in_word_t  item,
    output alrq_pkg::out_word_t result
);
    import alrq_pkg::*;

    // only SRC_COUNT sources are addressable, so the ring never needs more
    localparam int DEPTH = (NUM_SOURCES < SRC_COUNT) ? NUM_SOURCES : SRC_COUNT;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [DEPTH-1:0]  pending_reg;
    logic [DEPTH-1:0]  pending_next;
    logic [PTR_W-1:0]  order_reg [DEPTH];
    logic [DATA_W-1:0] value_reg [DEPTH];
    logic [PTR_W-1:0]  head_reg;
    logic [PTR_W-1:0]  head_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    logic [PTR_W-1:0]  src_idx;
    logic              src_ok;
    logic              do_push;
    logic              do_pop;
    logic              empty;
    logic [SUM_W-1:0]  tail_sum;
    logic [PTR_W-1:0]  tail;
    logic [PTR_W-1:0]  pop_src;
    logic [DATA_W-1:0] pop_val;
    logic [DATA_W-1:0] rd_data;
    logic              rd_nack;

    assign src_idx  = item.source_id[PTR_W-1:0];
    assign src_ok   = int'(item.source_id) < NUM_SOURCES;
    assign empty    = (count_reg == '0);
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail     = (tail_sum >= SUM_W'(DEPTH)) ? PTR_W'(tail_sum - SUM_W'(DEPTH))
                                                  : PTR_W'(tail_sum);
    assign pop_src  = order_reg[head_reg];
    assign pop_val  = value_reg[pop_src];

    always_comb
    begin
        do_push = 1'b0;
        do_pop  = 1'b0;
        rd_data = '0;
        rd_nack = 1'b0;
        unique case (item.operation)
            OP_ALERT:
            begin
                do_push = src_ok && !pending_reg[src_idx];
            end
            OP_RECV:
            begin
                do_pop  = !empty;
                rd_data = empty ? EMPTY_BYTE : pop_val;
            end
            OP_START_READ:
            begin
                rd_nack = empty;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        pending_next = pending_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        if (do_push)
        begin
            pending_next[src_idx] = 1'b1;
            count_next            = count_reg + CNT_W'(1);
        end
        if (do_pop)
        begin
            pending_next[pop_src] = 1'b0;
            head_next  = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign result = '{read_data: rd_data, nack: rd_nack, irq_level: (count_next != '0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
        end
        else if (step)
        begin
            pending_reg <= pending_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && do_push)
        begin
            order_reg[tail]    <= src_idx;
            value_reg[src_idx] <= item.alert_value;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_flags_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(pending_reg) == int'(count_reg))
        else $error("pending flags disagree with queue count");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        step && do_push |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not advance count");

    a_pop_counts: assert property (@(posedge clk) disable iff (!rst_n)
        step && do_pop |=> count_reg == $past(count_reg) - CNT_W'(1)
            && !pending_reg[$past(pop_src)])
        else $error("pop did not retire entry");

endmodule

>>> sv/alrq_out_reg.sv
module alrq_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  alrq_pkg::out_word_t result,
    output logic                busy,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output alrq_pkg::out_word_t rsp
);
    import alrq_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t rsp_reg;

    assign valid_next = step || (valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rsp_reg <= result;
        end
    end

    assign busy      = valid_reg && !rsp_ready;
    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> sv/smbus_alert_response_queue.sv
// SMBus alert response queue. Each request word is an alert (source_id,
// alert_value), a receive-byte, or a start-of-read check; each yields one
// response word. Alerts queue their source in arrival order unless already
// pending or out of range; receive-byte pops the oldest and returns its byte
// (0xFF when empty); start-of-read sets nack when empty; irq_level is high
// while any source is pending. One word per cycle sustained while the
// response side accepts: the queue update is combinational between the
// request register and the response register, and stalls on the response
// side hold the request register.
module smbus_alert_response_queue #(
    parameter int NUM_SOURCES = alrq_pkg::NUM_SOURCES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  alrq_pkg::in_word_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output alrq_pkg::out_word_t rsp
);
    import alrq_pkg::*;

    logic      held;
    logic      busy;
    logic      step;
    in_word_t  item;
    out_word_t result;

    assign step = held && !busy;

    alrq_in_reg u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .step      (step),
        .held      (held),
        .item      (item)
    );

    alrq_core #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .result (result)
    );

    alrq_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .result    (result),
        .busy      (busy),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

>>> tb/sv/smbus_alert_response_queue_tb.sv
module smbus_alert_response_queue_tb;

    import alrq_pkg::*;

    localparam int NSRC          = NUM_SOURCES_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_WORDS   = 332;
    localparam int HOLD_CYCLES   = 60;
    localparam int MAX_REPORTS   = 10;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        in_word_t  word;
        logic      typed;
        out_word_t want;
    } stim_row_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    in_word_t  req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    out_word_t rsp;

    // queue model state
    bit [NSRC-1:0]     pend_map = '0;
    bit [SRC_W-1:0]    fifo_src [NSRC];
    bit [DATA_W-1:0]   src_byte [NSRC];
    int                fifo_head = 0;
    int                fifo_count = 0;

    out_word_t   awaited_rsp[$];
    stim_row_t   stim_table[$];
    out_word_t   rsp_want;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_asks = 0;
    int          hold_done = 0;
    int          hold_left = 0;

    smbus_alert_response_queue dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic out_word_t predict_response(input in_word_t w);
        out_word_t        r;
        logic [SRC_W-1:0] s;
        r = '0;
        case (w.operation)
            OP_ALERT:
            begin
                if (w.source_id < NSRC && !pend_map[w.source_id] && fifo_count < NSRC)
                begin
                    pend_map[w.source_id] = 1'b1;
                    src_byte[w.source_id] = w.alert_value;
                    fifo_src[(fifo_head + fifo_count) % NSRC] = w.source_id;
                    fifo_count++;
                end
            end
            OP_RECV:
            begin
                if (fifo_count == 0)
                begin
                    r.read_data = EMPTY_BYTE;
                end
                else
                begin
                    s = fifo_src[fifo_head];
                    pend_map[s] = 1'b0;
                    r.read_data = src_byte[s];
                    fifo_head = (fifo_head + 1) % NSRC;
                    fifo_count--;
                end
            end
            OP_START_READ:
            begin
                r.nack = (fifo_count == 0);
            end
            default:
            begin
            end
        endcase
        r.irq_level = (fifo_count != 0);
        return r;
    endfunction

    function automatic void add_row(input logic [OP_W-1:0] op, input logic [SRC_W-1:0] src,
                                    input logic [DATA_W-1:0] val, input logic typed,
                                    input logic [DATA_W-1:0] data, input logic nack,
                                    input logic irq);
        stim_row_t row;
        row.word.operation   = op;
        row.word.source_id   = src;
        row.word.alert_value = val;
        row.typed            = typed;
        row.want.read_data   = data;
        row.want.nack        = nack;
        row.want.irq_level   = irq;
        stim_table.push_back(row);
    endfunction

    function automatic in_word_t random_word(input bit fill_bias);
        in_word_t w;
        int       roll;
        int       alert_thr;
        roll      = $urandom_range(0, 99);
        alert_thr = fill_bias ? 65 : 30;
        if (roll < alert_thr)
            w.operation = OP_ALERT;
        else if (roll < 88)
            w.operation = OP_RECV;
        else if (roll < 97)
            w.operation = OP_START_READ;
        else
            w.operation = OP_UNUSED;
        w.source_id   = SRC_W'($urandom_range(0, NSRC - 1));
        w.alert_value = DATA_W'($urandom_range(0, 255));
        return w;
    endfunction

    task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
        out_word_t predicted;
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = predict_response(w);
        awaited_rsp.push_back(typed ? want : predicted);
    endtask

    task automatic drain_responses();
        req_valid <= 1'b0;
        @(posedge clk);
        while (awaited_rsp.size() != 0)
            @(posedge clk);
    endtask

    // response checker and ready generator
    always @(posedge clk)
    begin
        if (rsp_valid && rsp_ready)
        begin
            if (awaited_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected response word: data=%0d nack=%0b irq=%0b",
                             rsp.read_data, rsp.nack, rsp.irq_level);
            end
            else
            begin
                rsp_want = awaited_rsp.pop_front();
                if (rsp.read_data !== rsp_want.read_data || rsp.nack !== rsp_want.nack ||
                    rsp.irq_level !== rsp_want.irq_level)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $write("response mismatch: exp data=%0d nack=%0b irq=%0b, ",
                               rsp_want.read_data, rsp_want.nack, rsp_want.irq_level);
                        $display("got data=%0d nack=%0b irq=%0b",
                                 rsp.read_data, rsp.nack, rsp.irq_level);
                    end
                end
            end
        end
        if (hold_done != hold_asks)
        begin
            hold_done = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int tx_pcts [4];
        int rx_pcts [4];
        tx_pcts = '{0, 60, 0, 10};
        rx_pcts = '{0, 0, 60, 10};

        // empty queue, unknown op, repeated alert, full queue, wrap
        add_row(OP_RECV,       3'd0, 8'h00, 1'b1, EMPTY_BYTE, 1'b0, 1'b0);
        add_row(OP_START_READ, 3'd0, 8'h00, 1'b1, 8'h00,      1'b1, 1'b0);
        add_row(OP_UNUSED,     3'd0, 8'h00, 1'b1, 8'h00,      1'b0, 1'b0);
        add_row(OP_ALERT,      3'd0, 8'h00, 1'b1, 8'h00,      1'b0, 1'b1);
        add_row(OP_START_READ, 3'd0, 8'h00, 1'b1, 8'h00,      1'b0, 1'b1);
        add_row(OP_ALERT,      3'd0, 8'hAA, 1'b1, 8'h00,      1'b0, 1'b1);
        add_row(OP_ALERT,      3'd7, 8'hFF, 1'b1, 8'h00,      1'b0, 1'b1);
        add_row(OP_UNUSED,     3'd5, 8'h5A, 1'b1, 8'h00,      1'b0, 1'b1);
        add_row(OP_RECV,       3'd7, 8'hFF, 1'b0, 8'h00,      1'b0, 1'b0);
        add_row(OP_RECV,       3'd0, 8'h00, 1'b0, 8'h00,      1'b0, 1'b0);
        add_row(OP_RECV,       3'd0, 8'h00, 1'b1, EMPTY_BYTE, 1'b0, 1'b0);
        add_row(OP_ALERT,      3'd3, 8'h13, 1'b0, 8'h00,      1'b0, 1'b0);
        add_row(OP_ALERT,      3'd6, 8'h80, 1'b0, 8'h00,      1'b0, 1'b0);
        add_row(OP_ALERT,      3'd1, 8'h01, 1'b0, 8'h00,      1'b0, 1'b0);
        add_row(OP_ALERT,      3'd0, 8'hFE, 1'b0, 8'h00,      1'b0, 1'b0);
        add_row(OP_ALERT,      3'd7, 8'h7F, 1'b0, 8'h00,      1'b0, 1'b0);
        add_row(OP_ALERT,      3'd2, 8'h55, 1'b0, 8'h00,      1'b0, 1'b0);
        add_row(OP_ALERT,      3'd5, 8'hC3, 1'b0, 8'h00,      1'b0, 1'b0);
        add_row(OP_ALERT,      3'd4, 8'h3C, 1'b0, 8'h00,      1'b0, 1'b0);
        add_row(OP_ALERT,      3'd3, 8'h99, 1'b0, 8'h00,      1'b0, 1'b0);
        add_row(OP_START_READ, 3'd7, 8'hFF, 1'b0, 8'h00,      1'b0, 1'b0);
        add_row(OP_RECV,       3'd2, 8'h22, 1'b0, 8'h00,      1'b0, 1'b0);
        add_row(OP_ALERT,      3'd3, 8'h81, 1'b0, 8'h00,      1'b0, 1'b0);
        add_row(OP_RECV,       3'd6, 8'h66, 1'b0, 8'h00,      1'b0, 1'b0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
            send_word(stim_table[i].word, stim_table[i].typed, stim_table[i].want);
        drain_responses();

        for (int ph = 0; ph < 4; ph++)
        begin
            tx_idle_pct  = tx_pcts[ph];
            rx_stall_pct = rx_pcts[ph];
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                // long receiver hold-off while words keep coming
                if ((ph == 0 || ph == 3) && i == PHASE_WORDS / 3)
                    hold_asks++;
                send_word(random_word(((i / 32) % 2) == 0), 1'b0, '0);
            end
            drain_responses();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
sv/alrq_pkg.sv
sv/alrq_in_reg.sv
sv/alrq_core.sv
sv/alrq_out_reg.sv
sv/smbus_alert_response_queue.sv
tb/sv/smbus_alert_response_queue_tb.sv
